// ===== hdl/tibl_pkg.sv =====
// ----------------------------------------------------------------------------
// tibl_pkg
// Shared codes, byte constants and types of the tape image block lexer.
// ----------------------------------------------------------------------------
package tibl_pkg;

	localparam int unsigned PhaseW = 3;

	localparam logic [PhaseW-1:0] PH_START   = 3'd0;
	localparam logic [PhaseW-1:0] PH_NOA5    = 3'd1;
	localparam logic [PhaseW-1:0] PH_NAME    = 3'd2;
	localparam logic [PhaseW-1:0] PH_TYPE    = 3'd3;
	localparam logic [PhaseW-1:0] PH_HEADER  = 3'd4;
	localparam logic [PhaseW-1:0] PH_PAYLOAD = 3'd5;
	localparam logic [PhaseW-1:0] PH_AFTER   = 3'd6;
	localparam logic [PhaseW-1:0] PH_ERROR   = 3'd7;

	localparam logic [2:0] KIND_SKIP    = 3'd0;
	localparam logic [2:0] KIND_OPEN    = 3'd1;
	localparam logic [2:0] KIND_NAME    = 3'd2;
	localparam logic [2:0] KIND_CLOSE   = 3'd3;
	localparam logic [2:0] KIND_BODY    = 3'd4;
	localparam logic [2:0] KIND_DISCARD = 3'd5;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_BAD_START = 3'd1;
	localparam logic [2:0] ERR_NAME      = 3'd2;
	localparam logic [2:0] ERR_BAD_TYPE  = 3'd3;
	localparam logic [2:0] ERR_SHORT_HDR = 3'd4;
	localparam logic [2:0] ERR_SHORT_PAY = 3'd5;

	localparam logic [1:0] FK_A = 2'd0;
	localparam logic [1:0] FK_B = 2'd1;
	localparam logic [1:0] FK_M = 2'd2;

	localparam logic [7:0] BYTE_SYNC  = 8'hA5;
	localparam logic [7:0] BYTE_A     = 8'h41;
	localparam logic [7:0] BYTE_B     = 8'h42;
	localparam logic [7:0] BYTE_M     = 8'h4D;
	localparam logic [7:0] BYTE_QUOTE = 8'h22;
	localparam logic [7:0] BYTE_ZERO  = 8'h00;

	localparam logic [2:0] HDR_LEN_A  = 3'd5;
	localparam logic [2:0] HDR_LEN_BM = 3'd3;
	localparam logic [3:0] EXTRA_A    = 4'd12;
	localparam logic [3:0] EXTRA_B    = 4'd3;
	localparam logic [3:0] EXTRA_M    = 4'd7;

	localparam int unsigned LeftW = 17;

	typedef struct packed {
		logic [7:0] echo_byte;
		logic [2:0] byte_kind;
		logic       body_first;
		logic       body_last;
		logic [2:0] error_code;
		logic       image_done;
		logic       image_ok;
	} result_t;

endpackage

// ===== hdl/tibl_fsm.sv =====
// ----------------------------------------------------------------------------
// tibl_fsm
// Lexer state and per-byte classification; state advances on step.
// ----------------------------------------------------------------------------
module tibl_fsm (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           data_byte,
	input  logic                 final_byte,
	output tibl_pkg::result_t    result
);

	logic [tibl_pkg::PhaseW-1:0] phase_q, phase_d, p;
	logic [2:0]                  hidx_q, hidx_d;
	logic [7:0]                  low_q, low_d;
	logic [tibl_pkg::LeftW-1:0]  left_q, left_d;
	logic [1:0]                  fkind_q, fkind_d;
	logic [2:0]                  err_q, err_d;
	logic [2:0]                  kind, e, hlen;
	logic [3:0]                  extra;
	logic                        first, last, ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tibl_pkg::PH_START;
			hidx_q  <= '0;
			low_q   <= '0;
			left_q  <= '0;
			fkind_q <= tibl_pkg::FK_A;
			err_q   <= tibl_pkg::ERR_NONE;
		end else if (step) begin
			phase_q <= phase_d;
			hidx_q  <= hidx_d;
			low_q   <= low_d;
			left_q  <= left_d;
			fkind_q <= fkind_d;
			err_q   <= err_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		hidx_d  = hidx_q;
		low_d   = low_q;
		left_d  = left_q;
		fkind_d = fkind_q;
		err_d   = err_q;
		kind    = tibl_pkg::KIND_DISCARD;
		first   = 1'b0;
		last    = 1'b0;
		ok      = 1'b0;
		e       = tibl_pkg::ERR_NONE;
		p       = phase_q;
		hlen    = (fkind_q == tibl_pkg::FK_A) ? tibl_pkg::HDR_LEN_A : tibl_pkg::HDR_LEN_BM;
		case (fkind_q)
			tibl_pkg::FK_A: extra = tibl_pkg::EXTRA_A;
			tibl_pkg::FK_B: extra = tibl_pkg::EXTRA_B;
			default:        extra = tibl_pkg::EXTRA_M;
		endcase

		if (p != tibl_pkg::PH_ERROR) begin
			if (p == tibl_pkg::PH_AFTER) begin
				if (data_byte == tibl_pkg::BYTE_ZERO) kind = tibl_pkg::KIND_SKIP;
				else p = tibl_pkg::PH_START;
			end
			if (p == tibl_pkg::PH_START && data_byte == tibl_pkg::BYTE_SYNC) begin
				kind    = tibl_pkg::KIND_SKIP;
				phase_d = tibl_pkg::PH_NOA5;
			end else if (p == tibl_pkg::PH_START || p == tibl_pkg::PH_NOA5) begin
				if (data_byte == tibl_pkg::BYTE_A) begin
					kind    = tibl_pkg::KIND_BODY;
					first   = 1'b1;
					fkind_d = tibl_pkg::FK_A;
					hidx_d  = 3'd1;
					phase_d = tibl_pkg::PH_HEADER;
				end else if (data_byte == tibl_pkg::BYTE_QUOTE) begin
					kind    = tibl_pkg::KIND_OPEN;
					phase_d = tibl_pkg::PH_NAME;
				end else begin
					e = tibl_pkg::ERR_BAD_START;
				end
			end else if (p == tibl_pkg::PH_NAME) begin
				if (data_byte == tibl_pkg::BYTE_ZERO) begin
					e = tibl_pkg::ERR_NAME;
				end else if (data_byte == tibl_pkg::BYTE_QUOTE) begin
					kind    = tibl_pkg::KIND_CLOSE;
					phase_d = tibl_pkg::PH_TYPE;
				end else begin
					kind = tibl_pkg::KIND_NAME;
				end
			end else if (p == tibl_pkg::PH_TYPE) begin
				if (data_byte == tibl_pkg::BYTE_A || data_byte == tibl_pkg::BYTE_B ||
						data_byte == tibl_pkg::BYTE_M) begin
					kind    = tibl_pkg::KIND_BODY;
					first   = 1'b1;
					if (data_byte == tibl_pkg::BYTE_A) fkind_d = tibl_pkg::FK_A;
					else if (data_byte == tibl_pkg::BYTE_B) fkind_d = tibl_pkg::FK_B;
					else fkind_d = tibl_pkg::FK_M;
					hidx_d  = 3'd1;
					phase_d = tibl_pkg::PH_HEADER;
				end else begin
					e = tibl_pkg::ERR_BAD_TYPE;
				end
			end else if (p == tibl_pkg::PH_HEADER) begin
				kind = tibl_pkg::KIND_BODY;
				if (hidx_q == hlen - 3'd2) low_d = data_byte;
				if (({1'b0, hidx_q} + 4'd1) >= {1'b0, hlen}) begin
					left_d  = {1'b0, data_byte, low_d} + {13'd0, extra};
					hidx_d  = '0;
					phase_d = tibl_pkg::PH_PAYLOAD;
				end else begin
					hidx_d = hidx_q + 3'd1;
				end
			end else if (p == tibl_pkg::PH_PAYLOAD) begin
				kind   = tibl_pkg::KIND_BODY;
				left_d = left_q - 17'd1;
				if (left_d == '0) begin
					last    = 1'b1;
					phase_d = tibl_pkg::PH_AFTER;
				end
			end
			if (e != tibl_pkg::ERR_NONE) begin
				kind    = tibl_pkg::KIND_DISCARD;
				first   = 1'b0;
				last    = 1'b0;
				err_d   = e;
				phase_d = tibl_pkg::PH_ERROR;
			end
		end

		if (final_byte && err_d == tibl_pkg::ERR_NONE && phase_d != tibl_pkg::PH_AFTER) begin
			if (phase_d == tibl_pkg::PH_NAME) err_d = tibl_pkg::ERR_NAME;
			else if (phase_d == tibl_pkg::PH_TYPE || phase_d == tibl_pkg::PH_HEADER)
				err_d = tibl_pkg::ERR_SHORT_HDR;
			else if (phase_d == tibl_pkg::PH_PAYLOAD) err_d = tibl_pkg::ERR_SHORT_PAY;
			else err_d = tibl_pkg::ERR_BAD_START;
		end
		if (final_byte) ok = (err_d == tibl_pkg::ERR_NONE);

		result.echo_byte  = data_byte;
		result.byte_kind  = kind;
		result.body_first = first;
		result.body_last  = last;
		result.error_code = err_d;
		result.image_done = final_byte;
		result.image_ok   = ok;

		if (final_byte) begin
			phase_d = tibl_pkg::PH_START;
			hidx_d  = '0;
			low_d   = '0;
			left_d  = '0;
			fkind_d = tibl_pkg::FK_A;
			err_d   = tibl_pkg::ERR_NONE;
		end
	end

endmodule

// ===== hdl/tape_image_block_lexer_top.sv =====
// ----------------------------------------------------------------------------
// tape_image_block_lexer_top
// Tags each tape image byte and tracks file framing and errors.
// Path: each input beat passes the input reg, then the result reg, to the output beat.
// Throughput: 1 byte per cycle while m_tready does not back-pressure the output.
// Reset: arst_n async active low clears both stage valid flags and all lexer state.
// ----------------------------------------------------------------------------
module tape_image_block_lexer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // final_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] echo_byte, [8] body_first, [9] body_last,
	                               // [12:10] error_code, [13] image_ok, [15:14] zero
	output logic [2:0]  m_tuser,   // [2:0] byte_kind
	output logic        m_tlast    // image_done
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              fin_s1;
	logic              out_free, advance;
	tibl_pkg::result_t res;
	tibl_pkg::result_t res_s2;
	logic              valid_s2;

	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			fin_s1  <= s_tlast;
		end
	end

	tibl_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (byte_s1),
		.final_byte (fin_s1),
		.result     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.image_ok, res_s2.error_code, res_s2.body_last,
		res_s2.body_first, res_s2.echo_byte};
	assign m_tuser  = res_s2.byte_kind;
	assign m_tlast  = res_s2.image_done;

	a_ok_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.image_ok |-> res_s2.image_done)
		else $error("image_ok without image_done");

	a_first_is_body: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (res_s2.body_first || res_s2.body_last) |->
			res_s2.byte_kind == tibl_pkg::KIND_BODY)
		else $error("body marker on non-body byte");

	a_discard_has_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_s2.byte_kind == tibl_pkg::KIND_DISCARD |->
			res_s2.error_code != tibl_pkg::ERR_NONE)
		else $error("discarded byte without error");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("input stalled with empty output");

endmodule
